@@ rtl/eld_audio_capability_parser_assert.svh @@
// Assertion macros used by the audio capability parser checker.
`ifndef ELD_AUDIO_CAPABILITY_PARSER_ASSERT_SVH
`define ELD_AUDIO_CAPABILITY_PARSER_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent, outside reset.
`define EACP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its antecedent, outside reset.
`define EACP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Check what must hold in the cycle after reset.
`define EACP_ASSERT_AFTER_RESET(lbl, clk, rst, cons, msg) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

@@ rtl/eld_acp_pkg.sv @@
// Types, constants and helpers of the ELD audio capability parser.
package eld_acp_pkg;

   // Block layout
   localparam int HEADER_BYTES          = 20;
   localparam int MAX_ELD_BYTES_DEFAULT = 256;
   localparam int POS_VERSION           = 0;
   localparam int POS_NAME_LEN          = 4;
   localparam int POS_SAD_COUNT         = 5;
   localparam int POS_SPEAKER           = 7;

   // Accepted ELD versions
   localparam logic [4:0] VER_CEA861D = 5'd2;
   localparam logic [4:0] VER_PARTIAL = 5'd31;

   // Raw audio coding types
   localparam logic [3:0] CT_LPCM      = 4'd1;
   localparam logic [3:0] CT_BITRATE_LO = 4'd2;
   localparam logic [3:0] CT_BITRATE_HI = 4'd8;
   localparam logic [3:0] CT_WMA       = 4'd14;
   localparam logic [3:0] CT_EXTENDED  = 4'd15;

   // Extended type codes that map onto coding types 15..17
   localparam logic [4:0] XT_FIRST   = 5'd1;
   localparam logic [4:0] XT_LAST    = 5'd3;
   localparam logic [4:0] XT_OFFSET  = 5'd14;
   localparam logic [4:0] XT_UNKNOWN = 5'd0;

   localparam logic [20:0] BITRATE_STEP = 21'd8000;
   localparam logic [3:0]  CHAN_FLOOR   = 4'd2;
   localparam logic [15:0] SPEAKER_ALL  = 16'hffff;

   // Descriptor byte phase
   localparam logic [1:0] PHASE_FIRST = 2'd0;
   localparam logic [1:0] PHASE_LAST  = 2'd2;

   // Summary status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_VER   = 2'd1;
   localparam logic [1:0] ST_NAME_OVER = 2'd2;
   localparam logic [1:0] ST_SAD_OVER  = 2'd3;

   // Record kinds
   localparam logic KIND_DESC    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Result queue
   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_PTR_W      = $clog2(RSP_FIFO_DEPTH);
   localparam int RSP_CNT_W      = $clog2(RSP_FIFO_DEPTH + 1);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        record_kind;
      logic [1:0]  status;
      logic [3:0]  count_or_index;
      logic [4:0]  coding_type;
      logic [3:0]  channels;
      logic [12:0] rate_mask;
      logic [2:0]  sample_size_mask;
      logic [20:0] bitrate_cap;
      logic [2:0]  wma_profile;
      logic [15:0] formats_mask;
      logic [3:0]  max_lpcm_channels;
      logic [15:0] speaker_alloc;
   } rsp_type;

   // Up to two records leave the parser per request, descriptor first
   typedef struct packed {
      logic    desc_valid;
      logic    sum_valid;
      rsp_type desc;
      rsp_type sum;
   } push_type;

   // Spread descriptor byte one onto the rate mask: bits 5..7 and 9..12
   function automatic logic [12:0] map_rates(input logic [6:0] b1);
      map_rates = {b1[6:3], 1'b0, b1[2:0], 5'b0};
   endfunction

endpackage

@@ rtl/eld_acp_parse.sv @@
// Header capture, descriptor decode and summary build of the ELD parser.
module eld_acp_parse
   import eld_acp_pkg::*;
#(
   parameter int MAX_ELD_BYTES = MAX_ELD_BYTES_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     step,
   input  req_type  item,
   output push_type push
);

   localparam int POS_W = $clog2(MAX_ELD_BYTES + 1);
   localparam int CMP_W = POS_W + 1;
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_ELD_BYTES);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             version_ok_ff, version_ok_in;
   logic [4:0]       name_len_ff, name_len_in;
   logic [3:0]       sad_total_ff, sad_total_in;
   logic [6:0]       speaker_ff, speaker_in;
   logic [7:0]       sad_byte_ff [2];
   logic [1:0]       phase_ff, phase_in;
   logic [3:0]       sad_cnt_ff, sad_cnt_in;
   logic [15:0]      formats_ff, formats_in;
   logic [3:0]       max_any_ff, max_any_in;
   logic [3:0]       max_pcm_ff, max_pcm_in;

   // values after this byte, before the end-of-block clear
   logic [POS_W-1:0] pos_upd;
   logic             version_ok_upd;
   logic [4:0]       name_len_upd;
   logic [3:0]       sad_total_upd;
   logic [6:0]       speaker_upd;
   logic [1:0]       phase_upd;
   logic [3:0]       sad_cnt_upd;
   logic [15:0]      formats_upd;
   logic [3:0]       max_any_upd;
   logic [3:0]       max_pcm_upd;

   logic             in_range;
   logic             in_window;
   logic             sad_store;
   logic             sad_fire;
   logic [CMP_W-1:0] start_cur;
   logic [CMP_W-1:0] start_upd;
   logic [CMP_W-1:0] block_size;
   logic [3:0]       raw;
   logic [3:0]       chans;
   logic [4:0]       ext_code;
   logic [4:0]       ctype;
   logic [1:0]       status;

   assign in_range  = pos_ff < POS_LIMIT;
   assign start_cur = CMP_W'(HEADER_BYTES) + CMP_W'(name_len_ff);
   assign in_window = version_ok_ff && ({1'b0, pos_ff} >= start_cur)
                      && (sad_cnt_ff < sad_total_ff);

   assign raw      = sad_byte_ff[0][6:3];
   assign chans    = {1'b0, sad_byte_ff[0][2:0]} + 4'd1;
   assign ext_code = item.data_byte[7:3];

   always_comb begin
      if (raw == CT_EXTENDED) begin
         if (ext_code inside {[XT_FIRST:XT_LAST]}) begin
            ctype = ext_code + XT_OFFSET;
         end else begin
            ctype = XT_UNKNOWN;
         end
      end else begin
         ctype = {1'b0, raw};
      end
   end

   always_comb begin
      pos_upd        = pos_ff;
      version_ok_upd = version_ok_ff;
      name_len_upd   = name_len_ff;
      sad_total_upd  = sad_total_ff;
      speaker_upd    = speaker_ff;
      phase_upd      = phase_ff;
      sad_cnt_upd    = sad_cnt_ff;
      formats_upd    = formats_ff;
      max_any_upd    = max_any_ff;
      max_pcm_upd    = max_pcm_ff;
      sad_store      = 1'b0;
      sad_fire       = 1'b0;

      if (step && in_range) begin
         pos_upd = pos_ff + 1'b1;
         if (pos_ff == POS_W'(POS_VERSION)) begin
            version_ok_upd = item.data_byte[7:3] inside {VER_CEA861D, VER_PARTIAL};
         end else if (pos_ff == POS_W'(POS_NAME_LEN)) begin
            name_len_upd = item.data_byte[4:0];
         end else if (pos_ff == POS_W'(POS_SAD_COUNT)) begin
            sad_total_upd = item.data_byte[7:4];
         end else if (pos_ff == POS_W'(POS_SPEAKER)) begin
            speaker_upd = item.data_byte[6:0];
         end else if (in_window) begin
            if (phase_ff == PHASE_LAST) begin
               sad_fire    = 1'b1;
               phase_upd   = PHASE_FIRST;
               sad_cnt_upd = sad_cnt_ff + 4'd1;
               formats_upd = formats_ff | (16'd1 << raw);
               if (chans > max_any_ff) begin
                  max_any_upd = chans;
               end
               if ((raw == CT_LPCM) && (chans > max_pcm_ff)) begin
                  max_pcm_upd = chans;
               end
            end else begin
               sad_store = 1'b1;
               phase_upd = phase_ff + 2'd1;
            end
         end
      end
   end

   // summary status from the state as it stands after this byte
   assign start_upd  = CMP_W'(HEADER_BYTES) + CMP_W'(name_len_upd);
   assign block_size = in_range ? (CMP_W'(pos_ff) + 1'b1) : CMP_W'(POS_LIMIT);

   always_comb begin
      if (!version_ok_upd) begin
         status = ST_BAD_VER;
      end else if (start_upd > block_size) begin
         status = ST_NAME_OVER;
      end else if (sad_cnt_upd < sad_total_upd) begin
         status = ST_SAD_OVER;
      end else begin
         status = ST_OK;
      end
   end

   // end of block: clear everything but the formats seen so far
   always_comb begin
      formats_in = formats_upd;
      if (step && item.last_byte) begin
         pos_in        = '0;
         version_ok_in = 1'b0;
         name_len_in   = '0;
         sad_total_in  = '0;
         speaker_in    = '0;
         phase_in      = PHASE_FIRST;
         sad_cnt_in    = '0;
         max_any_in    = CHAN_FLOOR;
         max_pcm_in    = CHAN_FLOOR;
      end else begin
         pos_in        = pos_upd;
         version_ok_in = version_ok_upd;
         name_len_in   = name_len_upd;
         sad_total_in  = sad_total_upd;
         speaker_in    = speaker_upd;
         phase_in      = phase_upd;
         sad_cnt_in    = sad_cnt_upd;
         max_any_in    = max_any_upd;
         max_pcm_in    = max_pcm_upd;
      end
   end

   always_comb begin
      push.desc_valid            = sad_fire;
      push.desc.record_kind      = KIND_DESC;
      push.desc.status           = ST_OK;
      push.desc.count_or_index   = sad_cnt_ff;
      push.desc.coding_type      = ctype;
      push.desc.channels         = chans;
      push.desc.rate_mask        = map_rates(sad_byte_ff[1][6:0]);
      push.desc.sample_size_mask = (raw == CT_LPCM) ? item.data_byte[2:0] : 3'd0;
      push.desc.bitrate_cap      = (raw inside {[CT_BITRATE_LO:CT_BITRATE_HI]})
                                   ? (21'(item.data_byte) * BITRATE_STEP) : 21'd0;
      push.desc.wma_profile      = (raw == CT_WMA) ? item.data_byte[2:0] : 3'd0;
      push.desc.formats_mask     = '0;
      push.desc.max_lpcm_channels = '0;
      push.desc.speaker_alloc    = '0;

      push.sum_valid             = step && item.last_byte;
      push.sum.record_kind       = KIND_SUMMARY;
      push.sum.status            = status;
      push.sum.count_or_index    = sad_total_upd;
      push.sum.coding_type       = '0;
      push.sum.channels          = max_any_upd;
      push.sum.rate_mask         = '0;
      push.sum.sample_size_mask  = '0;
      push.sum.bitrate_cap       = '0;
      push.sum.wma_profile       = '0;
      push.sum.formats_mask      = formats_upd;
      push.sum.max_lpcm_channels = max_pcm_upd;
      push.sum.speaker_alloc     = (speaker_upd != 7'd0) ? {9'd0, speaker_upd}
                                                         : SPEAKER_ALL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         version_ok_ff <= 1'b0;
         name_len_ff   <= '0;
         sad_total_ff  <= '0;
         speaker_ff    <= '0;
         phase_ff      <= PHASE_FIRST;
         sad_cnt_ff    <= '0;
         formats_ff    <= '0;
         max_any_ff    <= CHAN_FLOOR;
         max_pcm_ff    <= CHAN_FLOOR;
      end else begin
         pos_ff        <= pos_in;
         version_ok_ff <= version_ok_in;
         name_len_ff   <= name_len_in;
         sad_total_ff  <= sad_total_in;
         speaker_ff    <= speaker_in;
         phase_ff      <= phase_in;
         sad_cnt_ff    <= sad_cnt_in;
         formats_ff    <= formats_in;
         max_any_ff    <= max_any_in;
         max_pcm_ff    <= max_pcm_in;
      end
   end

   // hold the first two descriptor bytes until the third arrives
   always_ff @(posedge clock) begin
      if (sad_store) begin
         sad_byte_ff[phase_ff[0]] <= item.data_byte;
      end
   end

endmodule

@@ rtl/eld_acp_rsp_fifo.sv @@
// Result queue taking up to two records a cycle and giving one while rsp_stall is low.
module eld_acp_rsp_fifo
   import eld_acp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   rsp_type                mem_ff [RSP_FIFO_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic [RSP_PTR_W-1:0]   sum_slot;
   logic [1:0]             n_push;
   logic                   pop;

   assign rsp_valid = count_ff != '0;
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = count_ff <= RSP_CNT_W'(RSP_FIFO_DEPTH - 2);
   assign n_push    = 2'(push.desc_valid) + 2'(push.sum_valid);
   assign sum_slot  = push.desc_valid ? (wr_ptr_ff + 1'b1) : wr_ptr_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + RSP_CNT_W'(n_push) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.desc_valid) begin
         mem_ff[wr_ptr_ff] <= push.desc;
      end
      if (push.sum_valid) begin
         mem_ff[sum_slot] <= push.sum;
      end
   end

endmodule

@@ rtl/eld_audio_capability_parser.sv @@
// ELD audio capability parser: takes an ELD block one byte per request and
// returns one record per short audio descriptor plus a summary on the final
// byte. A request is taken in every cycle while the result side keeps up;
// each request is held in the input register, where version, name
// length, descriptor count and speaker bits are captured and the third byte
// of each descriptor is decoded, and its records land in a four-entry result
// queue, from which a record shows on rsp_ and is taken when rsp_stall is
// low. A final byte that also completes a descriptor yields two records,
// descriptor first and summary behind it in the queue. The input stalls only
// while a request is held and the queue has fewer than two free entries.
// The formats mask in the summary gathers every raw coding type seen since
// reset and is not cleared between blocks; all other per-block state returns
// to its reset value after the final byte. Bytes at positions MAX_ELD_BYTES
// and above are ignored and the block size then counts as MAX_ELD_BYTES.
module eld_audio_capability_parser
   import eld_acp_pkg::*;
#(
   parameter int MAX_ELD_BYTES = MAX_ELD_BYTES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     in_valid_ff, in_valid_in;
   req_type  in_item_ff;
   logic     accept;
   logic     advance;
   logic     fifo_room;
   push_type push;

   // Advance the held request once the queue can take both of its records;
   // stall the input only while a held request cannot advance.
   assign advance   = in_valid_ff && fifo_room;
   assign req_stall = in_valid_ff && !fifo_room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Hold the payload until the next request is accepted.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_data;
      end
   end

   // Parse the held byte against the block state.
   eld_acp_parse #(
      .MAX_ELD_BYTES(MAX_ELD_BYTES)
   ) u_parse (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_item_ff),
      .push  (push)
   );

   // Queue the records and present them one per cycle while rsp_stall is low.
   eld_acp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (fifo_room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/eld_acp_checker.sv @@
// Port-level checks of the ELD audio capability parser and their binding.
`include "eld_audio_capability_parser_assert.svh"

module eld_acp_checker
   import eld_acp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic ports_idle;
   logic rsp_held;
   logic sum_shown;
   logic sum_clean;
   logic desc_shown;
   logic desc_clean;

   assign ports_idle = !rsp_valid && !req_stall;
   assign rsp_held   = rsp_valid && rsp_stall;

   assign sum_shown  = rsp_valid && (rsp_data.record_kind == KIND_SUMMARY);
   assign sum_clean  = (rsp_data.coding_type == 5'd0) && (rsp_data.rate_mask == 13'd0)
                       && (rsp_data.bitrate_cap == 21'd0)
                       && (rsp_data.channels >= CHAN_FLOOR)
                       && (rsp_data.max_lpcm_channels >= CHAN_FLOOR);

   assign desc_shown = rsp_valid && (rsp_data.record_kind == KIND_DESC);
   assign desc_clean = (rsp_data.status == ST_OK) && (rsp_data.formats_mask == 16'd0)
                       && (rsp_data.max_lpcm_channels == 4'd0)
                       && (rsp_data.speaker_alloc == 16'd0) && (rsp_data.channels != 4'd0);

   `EACP_ASSERT_AFTER_RESET(a_reset_idle, clock, reset, ports_idle, "busy after reset")

   `EACP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data), "record moved")

   `EACP_ASSERT_NOW(a_sum_form, clock, reset, sum_shown, sum_clean, "bad summary")

   `EACP_ASSERT_NOW(a_desc_form, clock, reset, desc_shown, desc_clean, "bad descriptor")

endmodule

bind eld_audio_capability_parser eld_acp_checker u_eld_acp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
